FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define CHR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/chr_pkg.sv
package chr_pkg;

    localparam int CHAN_COUNT   = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int CHAN_BITS    = 3;

    localparam int RATIO_BITS = FRAC_BITS + 4;
    localparam int POS_BITS   = FRAC_BITS + 5;
    localparam int ACT_BITS   = 4;
    localparam int T_BITS     = FRAC_BITS + 1;
    localparam int COEF_BITS  = SAMPLE_BITS + 4;
    localparam int H_BITS     = SAMPLE_BITS + 6;
    localparam int PROD_BITS  = H_BITS + T_BITS;
    localparam int Y_BITS     = H_BITS + 1;

    localparam int RES_LIMIT = 32;
    localparam int CNT_BITS  = $clog2(RES_LIMIT + 1);

    localparam int ONE_POS    = 1 << FRAC_BITS;
    localparam int ROUND_HALF = 1 << FRAC_BITS;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = RATIO_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_RATIO      = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_CHANNELS = CFG_IDX_BITS'(1);

    localparam logic [RATIO_BITS-1:0] RATIO_RESET  = RATIO_BITS'(ONE_POS);
    localparam logic [ACT_BITS-1:0]   ACTIVE_RESET = ACT_BITS'(1);

    localparam logic [1:0] PCNT_CUR  = 2'd0;
    localparam logic [1:0] PCNT_NEXT = 2'd1;
    localparam logic [1:0] PCNT_LAST = 2'd2;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_UPDATE,
        OP_COEF,
        OP_MUL_A,
        OP_ADD_B,
        OP_MUL_H,
        OP_ADD_C,
        OP_ROUND,
        OP_EMIT,
        OP_BYPASS
    } t_dp_op;

    typedef struct packed {
        logic inactive;
        logic bypass;
        logic prime_hold;
        logic more;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_COEF,
        ST_CHECK,
        ST_MUL_A,
        ST_ADD_B,
        ST_MUL_B,
        ST_ADD_C,
        ST_MUL_C,
        ST_ROUND,
        ST_EMIT,
        ST_BYPASS
    } t_ctl_state;

endpackage

FILE: sv/chr_smp_if.sv
interface chr_smp_if;
    import chr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CHAN_BITS-1:0]          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink (input valid, input channel, input sample_in, output ready);

endinterface

FILE: sv/chr_res_if.sv
interface chr_res_if;
    import chr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CHAN_BITS-1:0]          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last;

    modport source (output valid, output channel_out, output sample_out, output last,
                    input ready);
    modport sink (input valid, input channel_out, input sample_out, input last,
                  output ready);

endinterface

FILE: sv/chr_cfg_if.sv
interface chr_cfg_if;
    import chr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

FILE: sv/cubic_hermite_resampler_core.sv
// Multichannel sample-rate converter with 4-point cubic Hermite (Catmull-Rom)
// interpolation. Each transaction on i_smp carries one channel-tagged signed
// Q1.23 sample; o_res returns the interpolated samples it causes, tagged with
// the same channel, with last set on the final one. Every channel keeps its
// own four-sample history, Q.16 read position and priming count. After reset
// or any write to rate_ratio (index 0, unsigned Q4.16 input over output rate)
// or active_channels (index 1), every channel re-primes: its first three
// samples fill the history and the third already produces output. A ratio of
// exactly 1.0 passes each sample straight through as one result. Samples on a
// channel at or above active_channels are dropped silently. At most 32
// results follow one input. Write configuration only while the block is idle;
// i_cfg is always ready.
// Timing: one input is processed at a time. A sample that is dropped or only
// primes the history is loaded and updated; a bypassed sample then waits for
// a free output register. Each Horner result needs three passes through one
// shared 30x17 multiplier, the first two each followed by a registered add,
// the third by a rounding and saturation step. A registered output stage
// holds the newest result, so the datapath keeps computing the next one
// while the sink stalls.
module cubic_hermite_resampler_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chr_smp_if.sink   i_smp,
    chr_res_if.source o_res,
    chr_cfg_if.sink   i_cfg
);
    import chr_pkg::*;

    t_dp_op   cmd;
    t_dp_stat stat;
    logic     in_ready;

    // Config writes are never stalled
    assign i_cfg.ready = 1'b1;
    assign i_smp.ready = in_ready;

    // Sequencer: accept, update history, then step the Horner passes
    chr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Per-channel state, config registers, multiplier and output register
    chr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_channel  (i_smp.channel),
        .i_in_sample   (i_smp.sample_in),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .o_out_channel (o_res.channel_out),
        .o_out_sample  (o_res.sample_out),
        .o_out_last    (o_res.last)
    );

endmodule

FILE: sv/chr_ctrl.sv
module chr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  chr_pkg::t_dp_stat i_stat,
    output chr_pkg::t_dp_op   o_cmd
);
    import chr_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = OP_LOAD;
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd = OP_UPDATE;
                priority if (i_stat.inactive) begin
                    n_state = ST_IDLE;
                end else if (i_stat.bypass) begin
                    n_state = ST_BYPASS;
                end else if (i_stat.prime_hold) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_COEF;
                end
            end
            ST_COEF: begin
                o_cmd   = OP_COEF;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.more ? ST_MUL_A : ST_IDLE;
            end
            ST_MUL_A: begin
                o_cmd   = OP_MUL_A;
                n_state = ST_ADD_B;
            end
            ST_ADD_B: begin
                o_cmd   = OP_ADD_B;
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd   = OP_MUL_H;
                n_state = ST_ADD_C;
            end
            ST_ADD_C: begin
                o_cmd   = OP_ADD_C;
                n_state = ST_MUL_C;
            end
            ST_MUL_C: begin
                o_cmd   = OP_MUL_H;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd   = OP_ROUND;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd   = OP_EMIT;
                    n_state = ST_CHECK;
                end
            end
            ST_BYPASS: begin
                if (i_stat.out_free) begin
                    o_cmd   = OP_BYPASS;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/chr_datapath.sv
module chr_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  chr_pkg::t_dp_op                        i_cmd,
    output chr_pkg::t_dp_stat                      o_stat,
    input  logic [chr_pkg::CHAN_BITS-1:0]          i_in_channel,
    input  logic signed [chr_pkg::SAMPLE_BITS-1:0] i_in_sample,
    input  logic                                   i_cfg_valid,
    input  logic [chr_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [chr_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [chr_pkg::CHAN_BITS-1:0]          o_out_channel,
    output logic signed [chr_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                                   o_out_last
);
    import chr_pkg::*;

    // Config
    logic [RATIO_BITS-1:0] r_ratio;
    logic [ACT_BITS-1:0]   r_active;

    // Current item
    logic [CHAN_BITS-1:0]          r_ch;
    logic signed [SAMPLE_BITS-1:0] r_smp;

    // Per-channel state
    logic signed [SAMPLE_BITS-1:0] r_prev  [CHAN_COUNT];
    logic signed [SAMPLE_BITS-1:0] r_cur   [CHAN_COUNT];
    logic signed [SAMPLE_BITS-1:0] r_next  [CHAN_COUNT];
    logic signed [SAMPLE_BITS-1:0] r_next2 [CHAN_COUNT];
    logic [POS_BITS-1:0]           r_pos   [CHAN_COUNT];
    logic [1:0]                    r_pcnt  [CHAN_COUNT];
    logic                          r_nprime[CHAN_COUNT];

    // Horner working registers
    logic signed [COEF_BITS-1:0]   r_a;
    logic signed [COEF_BITS-1:0]   r_b;
    logic signed [COEF_BITS-1:0]   r_c;
    logic signed [H_BITS-1:0]      r_h;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic [CNT_BITS-1:0]           r_n;

    // Output register
    logic                          r_out_valid;
    logic [CHAN_BITS-1:0]          r_out_ch;
    logic signed [SAMPLE_BITS-1:0] r_out_smp;
    logic                          r_out_last;

    logic                          cfg_hit;
    logic [POS_BITS-1:0]           cur_pos;
    logic [POS_BITS-1:0]           pos_step;
    logic                          res_last;
    logic signed [COEF_BITS-1:0]   p_x;
    logic signed [COEF_BITS-1:0]   c0_x;
    logic signed [COEF_BITS-1:0]   c1_x;
    logic signed [COEF_BITS-1:0]   c2_x;
    logic signed [COEF_BITS-1:0]   d_x;
    logic signed [COEF_BITS-1:0]   a_val;
    logic signed [COEF_BITS-1:0]   b_val;
    logic signed [COEF_BITS-1:0]   c_val;
    logic signed [T_BITS-1:0]      t_s;
    logic signed [H_BITS-1:0]      mul_op;
    logic signed [PROD_BITS-1:0]   mul_res;
    logic signed [PROD_BITS-1:0]   rnd_sum;
    logic signed [PROD_BITS-1:0]   rnd_shift;
    logic signed [Y_BITS-1:0]      y_wide;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          upd_en;
    logic                          emit_any;

    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == CFG_RATE_RATIO || i_cfg_index == CFG_ACTIVE_CHANNELS);

    assign cur_pos  = r_pos[r_ch];
    assign pos_step = cur_pos + POS_BITS'(r_ratio);
    assign res_last = (pos_step >= POS_BITS'(ONE_POS)) || (r_n == CNT_BITS'(RES_LIMIT - 1));

    assign o_stat.inactive   = (ACT_BITS'(r_ch) >= r_active) || (int'(r_ch) >= CHAN_COUNT);
    assign o_stat.bypass     = (r_ratio == RATIO_RESET);
    assign o_stat.prime_hold = r_nprime[r_ch] && !r_pcnt[r_ch][1];
    assign o_stat.more       = (cur_pos < POS_BITS'(ONE_POS)) && (r_n < CNT_BITS'(RES_LIMIT));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign upd_en   = (i_cmd == OP_UPDATE) && !o_stat.inactive && !o_stat.bypass;
    assign emit_any = (i_cmd == OP_EMIT) || (i_cmd == OP_BYPASS);

    // Doubled Catmull-Rom coefficients, exact
    assign p_x   = COEF_BITS'(r_prev[r_ch]);
    assign c0_x  = COEF_BITS'(r_cur[r_ch]);
    assign c1_x  = COEF_BITS'(r_next[r_ch]);
    assign c2_x  = COEF_BITS'(r_next2[r_ch]);
    assign d_x   = c0_x - c1_x;
    assign a_val = (d_x <<< 1) + d_x - p_x + c2_x;
    assign b_val = (c1_x <<< 2) + (p_x <<< 1) - ((c0_x <<< 2) + c0_x) - c2_x;
    assign c_val = c1_x - p_x;

    // Shared multiplier: coefficient or partial sum times the fraction
    assign t_s     = signed'({1'b0, cur_pos[FRAC_BITS-1:0]});
    assign mul_op  = (i_cmd == OP_MUL_A) ? H_BITS'(r_a) : r_h;
    assign mul_res = mul_op * t_s;

    assign rnd_sum   = r_prod + PROD_BITS'(ROUND_HALF);
    assign rnd_shift = rnd_sum >>> (FRAC_BITS + 1);
    assign y_wide    = Y_BITS'(r_cur[r_ch]) + Y_BITS'(rnd_shift);

    always_comb begin
        priority if (y_wide > Y_BITS'(SAMPLE_MAX)) begin
            y_sat = SAMPLE_MAX;
        end else if (y_wide < Y_BITS'(SAMPLE_MIN)) begin
            y_sat = SAMPLE_MIN;
        end else begin
            y_sat = SAMPLE_BITS'(y_wide);
        end
    end

    // Control state: config, priming, result count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= RATIO_RESET;
            r_active    <= ACTIVE_RESET;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            for (int i = 0; i < CHAN_COUNT; i++) begin
                r_pcnt[i]   <= PCNT_CUR;
                r_nprime[i] <= 1'b1;
            end
        end else begin
            if (emit_any) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd == OP_COEF) begin
                r_n <= '0;
            end else if (i_cmd == OP_EMIT) begin
                r_n <= r_n + CNT_BITS'(1);
            end

            if (upd_en && r_nprime[r_ch]) begin
                unique case (r_pcnt[r_ch])
                    PCNT_CUR:  r_pcnt[r_ch] <= PCNT_NEXT;
                    PCNT_NEXT: r_pcnt[r_ch] <= PCNT_LAST;
                    default: begin
                        r_pcnt[r_ch]   <= PCNT_CUR;
                        r_nprime[r_ch] <= 1'b0;
                    end
                endcase
            end

            // A write to rate_ratio or active_channels re-primes every channel
            if (cfg_hit) begin
                if (i_cfg_index == CFG_RATE_RATIO) begin
                    r_ratio <= i_cfg_data[RATIO_BITS-1:0];
                end else begin
                    r_active <= i_cfg_data[ACT_BITS-1:0];
                end
                for (int i = 0; i < CHAN_COUNT; i++) begin
                    r_pcnt[i]   <= PCNT_CUR;
                    r_nprime[i] <= 1'b1;
                end
            end
        end
    end

    // Payload: current item, history, position, Horner pipeline, output data
    always_ff @(posedge i_clk) begin
        if (i_cmd == OP_LOAD) begin
            r_ch  <= i_in_channel;
            r_smp <= i_in_sample;
        end

        if (upd_en) begin
            if (r_nprime[r_ch]) begin
                unique case (r_pcnt[r_ch])
                    PCNT_CUR:  r_cur[r_ch]  <= r_smp;
                    PCNT_NEXT: r_next[r_ch] <= r_smp;
                    default: begin
                        r_next2[r_ch] <= r_smp;
                        r_prev[r_ch]  <= '0;
                        r_pos[r_ch]   <= '0;
                    end
                endcase
            end else begin
                r_prev[r_ch]  <= r_cur[r_ch];
                r_cur[r_ch]   <= r_next[r_ch];
                r_next[r_ch]  <= r_next2[r_ch];
                r_next2[r_ch] <= r_smp;
                if (cur_pos >= POS_BITS'(ONE_POS)) begin
                    r_pos[r_ch] <= cur_pos - POS_BITS'(ONE_POS);
                end else begin
                    r_pos[r_ch] <= '0;
                end
            end
        end

        if (i_cmd == OP_COEF) begin
            r_a <= a_val;
            r_b <= b_val;
            r_c <= c_val;
        end

        if (i_cmd == OP_MUL_A || i_cmd == OP_MUL_H) begin
            r_prod <= mul_res;
        end

        if (i_cmd == OP_ADD_B) begin
            r_h <= H_BITS'(r_prod >>> FRAC_BITS) + H_BITS'(r_b);
        end else if (i_cmd == OP_ADD_C) begin
            r_h <= H_BITS'(r_prod >>> FRAC_BITS) + H_BITS'(r_c);
        end

        if (i_cmd == OP_ROUND) begin
            r_y <= y_sat;
        end

        if (i_cmd == OP_EMIT) begin
            r_pos[r_ch] <= pos_step;
            r_out_ch    <= r_ch;
            r_out_smp   <= r_y;
            r_out_last  <= res_last;
        end else if (i_cmd == OP_BYPASS) begin
            r_out_ch   <= r_ch;
            r_out_smp  <= r_smp;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_out_sample  = r_out_smp;
    assign o_out_last    = r_out_last;

endmodule

FILE: sv/chr_checker.sv
`include "assert_macros.svh"

module chr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_smp_valid,
    input logic i_smp_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_last
);

    logic smp_xfer;
    logic res_xfer;

    assign smp_xfer = i_smp_valid && i_smp_ready;
    assign res_xfer = i_res_valid && i_res_ready;

    // Hold a stalled result
    `CHR_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid, "result dropped while stalled")

    // Reset empties the output register
    `CHR_ASSERT_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !i_res_valid, "result valid after reset")

    // One input at a time: no accept right after an accept
    `CHR_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, smp_xfer, !i_smp_ready, "input taken while busy")

    // A run of results is not interleaved with new input
    `CHR_ASSERT_SAME(a_run_closed, i_clk, i_rst_n, res_xfer && !i_res_last, !i_smp_ready, "input ready before last result")

endmodule

bind cubic_hermite_resampler_core chr_checker u_chr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_smp_valid (i_smp.valid),
    .i_smp_ready (i_smp.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_last  (o_res.last)
);

FILE: verif/tb_cubic_hermite_resampler_core.sv
`timescale 1ns / 100ps

module tb_cubic_hermite_resampler_core;
    import chr_pkg::*;

    localparam int ITEM_TARGET  = 420;
    localparam int DRAIN_CYCLES = 24;    // covers a dropped or priming sample still in flight
    localparam int END_CYCLES   = 40;
    localparam int STALL_LIMIT  = 4000;  // cycles without any transaction
    localparam int SHOW_LIMIT   = 30;

    localparam logic [RATIO_BITS-1:0] RATIO_UNITY = RATIO_BITS'(ONE_POS);
    localparam int RATIO_LO = ONE_POS / RES_LIMIT;   // lowest ratio that never hits the cap
    localparam int RATIO_HI = (1 << RATIO_BITS) - 1;
    localparam int CFG_IDX_SPARE_LO = int'(CFG_ACTIVE_CHANNELS) + 1;
    localparam int CFG_IDX_TOP      = (1 << CFG_IDX_BITS) - 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = CFG_IDX_BITS'(9);

    typedef enum logic [1:0] {
        ROW_CFG,    // register write
        ROW_PRED,   // sample, results come from the predictor
        ROW_PASS,   // sample, expect it back unchanged with last set
        ROW_DROP    // sample, expect nothing
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [CFG_IDX_BITS-1:0]       idx;
        logic [CFG_DATA_BITS-1:0]      data;
        logic [CHAN_BITS-1:0]          ch;
        logic signed [SAMPLE_BITS-1:0] smp;
    } t_script_row;

    typedef struct packed {
        logic [CHAN_BITS-1:0]          ch;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          last;
    } t_out_sample;

    // Directed opening: bypass after reset, inactive tags, full-scale overshoot,
    // both ratio extremes, a ratio under the result cap, a spare register index.
    localparam int SCRIPT_LEN = 35;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{ROW_PASS, '0, '0, 3'd0, SAMPLE_MAX},
        '{ROW_PASS, '0, '0, 3'd0, SAMPLE_MIN},
        '{ROW_PASS, '0, '0, 3'd0, 24'sd0},
        '{ROW_DROP, '0, '0, 3'd7, 24'sh123456},
        '{ROW_DROP, '0, '0, 3'd1, -24'sd1},
        '{ROW_CFG,  CFG_ACTIVE_CHANNELS, CFG_DATA_BITS'(8), '0, '0},
        '{ROW_PASS, '0, '0, 3'd7, -24'sd5},
        '{ROW_CFG,  CFG_RATE_RATIO, CFG_DATA_BITS'(32768), '0, '0},
        '{ROW_PRED, '0, '0, 3'd0, SAMPLE_MAX},
        '{ROW_PRED, '0, '0, 3'd0, SAMPLE_MIN},
        '{ROW_PRED, '0, '0, 3'd0, SAMPLE_MAX},
        '{ROW_PRED, '0, '0, 3'd0, SAMPLE_MIN},
        '{ROW_PRED, '0, '0, 3'd0, SAMPLE_MAX},
        '{ROW_CFG,  CFG_RATE_RATIO, CFG_DATA_BITS'(RATIO_LO), '0, '0},
        '{ROW_PRED, '0, '0, 3'd3, 24'sd100},
        '{ROW_PRED, '0, '0, 3'd3, -24'sd200},
        '{ROW_PRED, '0, '0, 3'd3, 24'sd300},
        '{ROW_PRED, '0, '0, 3'd3, 24'sd7},
        '{ROW_CFG,  CFG_RATE_RATIO, CFG_DATA_BITS'(RATIO_HI), '0, '0},
        '{ROW_PRED, '0, '0, 3'd6, 24'sh3fffff},
        '{ROW_PRED, '0, '0, 3'd6, -24'sh2abcde},
        '{ROW_PRED, '0, '0, 3'd6, 24'sh012345},
        '{ROW_PRED, '0, '0, 3'd6, SAMPLE_MIN},
        '{ROW_CFG,  CFG_RATE_RATIO, CFG_DATA_BITS'(1000), '0, '0},
        '{ROW_PRED, '0, '0, 3'd1, 24'sh100000},
        '{ROW_PRED, '0, '0, 3'd1, -24'sh100000},
        '{ROW_PRED, '0, '0, 3'd1, 24'sh050000},
        '{ROW_PRED, '0, '0, 3'd1, 24'sh7ff000},
        '{ROW_CFG,  CFG_IDX_SPARE, CFG_DATA_BITS'(1), '0, '0},
        '{ROW_PRED, '0, '0, 3'd1, -24'sh000777},
        '{ROW_CFG,  CFG_ACTIVE_CHANNELS, CFG_DATA_BITS'(0), '0, '0},
        '{ROW_DROP, '0, '0, 3'd0, 24'sd55},
        '{ROW_CFG,  CFG_ACTIVE_CHANNELS, CFG_DATA_BITS'(15), '0, '0},
        '{ROW_CFG,  CFG_RATE_RATIO, CFG_DATA_BITS'(ONE_POS + 1), '0, '0},
        '{ROW_PRED, '0, '0, 3'd7, 24'sd1}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    chr_smp_if smp_bus ();
    chr_res_if res_bus ();
    chr_cfg_if cfg_bus ();

    cubic_hermite_resampler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus.sink),
        .o_res   (res_bus.source),
        .i_cfg   (cfg_bus.sink)
    );

    // Shadow of the converter: per-channel history, position and priming.
    logic signed [SAMPLE_BITS-1:0] hist_prev  [CHAN_COUNT];
    logic signed [SAMPLE_BITS-1:0] hist_cur   [CHAN_COUNT];
    logic signed [SAMPLE_BITS-1:0] hist_next  [CHAN_COUNT];
    logic signed [SAMPLE_BITS-1:0] hist_next2 [CHAN_COUNT];
    logic [POS_BITS-1:0]           read_pos   [CHAN_COUNT];
    logic [1:0]                    prime_cnt  [CHAN_COUNT];
    bit                            priming    [CHAN_COUNT];
    logic [RATIO_BITS-1:0]         ratio_q;
    logic [ACT_BITS-1:0]           active_q;

    t_out_sample awaited [$];
    int          mismatches = 0;
    int          quiet_cycles;
    bit          rx_steady;
    int          rx_stall_left;
    int          rx_mode_cycles;

    always #2 i_clk = ~i_clk;

    task automatic log_mismatch(input string what);
        if (mismatches < SHOW_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] hermite(input int ch,
                                                               input logic [POS_BITS-1:0] t);
        longint p, c0, c1, c2, a, b, c, tt, h, y;
        p  = longint'(hist_prev[ch]);
        c0 = longint'(hist_cur[ch]);
        c1 = longint'(hist_next[ch]);
        c2 = longint'(hist_next2[ch]);
        tt = longint'(t);
        // doubled Catmull-Rom coefficients, exact
        a = 3 * (c0 - c1) - p + c2;
        b = 4 * c1 + 2 * p - 5 * c0 - c2;
        c = c1 - p;
        h = ((a * tt) >>> FRAC_BITS) + b;
        h = ((h * tt) >>> FRAC_BITS) + c;
        h = h * tt;
        y = c0 + ((h + (longint'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        return SAMPLE_BITS'(y);
    endfunction

    task automatic reset_shadow();
        for (int i = 0; i < CHAN_COUNT; i++) begin
            hist_prev[i]  = '0;
            hist_cur[i]   = '0;
            hist_next[i]  = '0;
            hist_next2[i] = '0;
            read_pos[i]   = '0;
            prime_cnt[i]  = PCNT_CUR;
            priming[i]    = 1'b1;
        end
        ratio_q  = RATIO_RESET;
        active_q = ACTIVE_RESET;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_RATE_RATIO)
            ratio_q = data[RATIO_BITS-1:0];
        else if (idx == CFG_ACTIVE_CHANNELS)
            active_q = data[ACT_BITS-1:0];
        else
            return;
        // any real register write re-primes every channel
        for (int i = 0; i < CHAN_COUNT; i++) begin
            priming[i]   = 1'b1;
            prime_cnt[i] = PCNT_CUR;
        end
    endtask

    // Queue the interpolated samples that one accepted input produces.
    task automatic resample_step(input logic [CHAN_BITS-1:0] ch,
                                 input logic signed [SAMPLE_BITS-1:0] s);
        t_out_sample         r;
        int                  n;
        int                  c;
        logic [POS_BITS-1:0] nxt;
        c = int'(ch);
        if ({1'b0, ch} >= active_q)
            return;
        if (ratio_q == RATIO_UNITY) begin
            awaited.push_back(t_out_sample'{ch, s, 1'b1});
            return;
        end
        if (priming[c]) begin
            unique case (prime_cnt[c])
                PCNT_CUR: begin
                    hist_cur[c]  = s;
                    prime_cnt[c] = PCNT_NEXT;
                    return;
                end
                PCNT_NEXT: begin
                    hist_next[c] = s;
                    prime_cnt[c] = PCNT_LAST;
                    return;
                end
                default: begin
                    hist_next2[c] = s;
                    hist_prev[c]  = '0;
                    read_pos[c]   = '0;
                    prime_cnt[c]  = PCNT_CUR;
                    priming[c]    = 1'b0;
                end
            endcase
        end else begin
            hist_prev[c]  = hist_cur[c];
            hist_cur[c]   = hist_next[c];
            hist_next[c]  = hist_next2[c];
            hist_next2[c] = s;
            // a capped run leaves the position below one: clamp instead of wrap
            if (read_pos[c] >= POS_BITS'(ONE_POS))
                read_pos[c] = read_pos[c] - POS_BITS'(ONE_POS);
            else
                read_pos[c] = '0;
        end
        n = 0;
        while (read_pos[c] < POS_BITS'(ONE_POS) && n < RES_LIMIT) begin
            nxt    = read_pos[c] + POS_BITS'(ratio_q);
            r.ch   = ch;
            r.smp  = hermite(c, read_pos[c]);
            r.last = !(nxt < POS_BITS'(ONE_POS) && n + 1 < RES_LIMIT);
            awaited.push_back(r);
            read_pos[c] = nxt;
            n++;
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic hold_sender(input int n);
        if (n > 0) begin
            smp_bus.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [CHAN_BITS-1:0] ch,
                               input logic signed [SAMPLE_BITS-1:0] s,
                               input t_row_kind how);
        smp_bus.valid     <= 1'b1;
        smp_bus.channel   <= ch;
        smp_bus.sample_in <= s;
        do @(posedge i_clk); while (!smp_bus.ready);
        unique case (how)
            ROW_PASS: awaited.push_back(t_out_sample'{ch, s, 1'b1});
            ROW_DROP: ;
            default:  resample_step(ch, s);
        endcase
    endtask

    // Hold off until every expected result is out and the datapath has settled.
    task automatic drain_outputs();
        smp_bus.valid <= 1'b0;
        while (awaited.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        drain_outputs();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_ratio();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)  return CFG_DATA_BITS'(ONE_POS);
        if (r < 6)  return CFG_DATA_BITS'($urandom_range(RATIO_LO, 16383));
        if (r < 11) return CFG_DATA_BITS'($urandom_range(16384, 131071));
        if (r < 13) return CFG_DATA_BITS'($urandom_range(131072, RATIO_HI));
        if (r == 13) return CFG_DATA_BITS'($urandom_range(0, 1) ? RATIO_HI : RATIO_LO);
        if (r == 14) return CFG_DATA_BITS'($urandom_range(0, RATIO_LO - 1));
        return CFG_DATA_BITS'($urandom_range(0, 1) ? ONE_POS + 1 : ONE_POS - 1);
    endfunction

    function automatic logic [ACT_BITS-1:0] pick_active();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 3)  return ACT_BITS'($urandom_range(CHAN_COUNT + 1, (1 << ACT_BITS) - 1));
        return ACT_BITS'($urandom_range(1, CHAN_COUNT));
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return SAMPLE_MAX;
        if (r == 1) return SAMPLE_MIN;
        return SAMPLE_BITS'($urandom());
    endfunction

    // Result side: check each transaction against the oldest expectation,
    // then pick ready for the next cycle.
    always @(posedge i_clk) begin
        t_out_sample want;
        if (!i_rst_n) begin
            res_bus.ready  <= 1'b0;
            rx_stall_left  = 0;
            rx_steady      = 1'b0;
            rx_mode_cycles = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (awaited.size() == 0) begin
                    log_mismatch($sformatf("unexpected result ch %0d sample %0d",
                                           res_bus.channel_out, res_bus.sample_out));
                end else begin
                    want = awaited.pop_front();
                    if (res_bus.channel_out !== want.ch)
                        log_mismatch($sformatf("channel got %0d want %0d",
                                               res_bus.channel_out, want.ch));
                    if (res_bus.sample_out !== want.smp)
                        log_mismatch($sformatf("ch %0d sample got %0d want %0d",
                                               want.ch, res_bus.sample_out, want.smp));
                    if (res_bus.last !== want.last)
                        log_mismatch($sformatf("ch %0d last got %0b want %0b",
                                               want.ch, res_bus.last, want.last));
                end
            end
            // alternate stretches of free-running and stalling sink
            if (rx_mode_cycles == 0) begin
                rx_steady      = ($urandom_range(0, 3) == 0);
                rx_mode_cycles = $urandom_range(100, 400);
            end else begin
                rx_mode_cycles--;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                res_bus.ready <= 1'b0;
            end else begin
                if (!rx_steady && $urandom_range(0, 2) == 0)
                    rx_stall_left = gap_len();
                res_bus.ready <= (rx_stall_left == 0);
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                            live;
        int                            phase_len;
        bit                            tx_steady;
        logic [CHAN_BITS-1:0]          ch;
        logic [ACT_BITS-1:0]           act;
        logic [CFG_IDX_BITS-1:0]       spare;
        logic signed [SAMPLE_BITS-1:0] s;

        i_rst_n           = 1'b0;
        smp_bus.valid     = 1'b0;
        smp_bus.channel   = '0;
        smp_bus.sample_in = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        live = 0;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].kind == ROW_CFG) begin
                write_reg(SCRIPT[i].idx, SCRIPT[i].data);
            end else begin
                hold_sender(gap_len());
                send_sample(SCRIPT[i].ch, SCRIPT[i].smp, SCRIPT[i].kind);
                live++;
            end
        end

        // random phases: new settings, then a burst of mostly well-tagged samples
        while (live < ITEM_TARGET) begin
            act = pick_active();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_RATE_RATIO, pick_ratio());
                write_reg(CFG_ACTIVE_CHANNELS,
                          CFG_DATA_BITS'({16'($urandom()), act}));
            end else begin
                write_reg(CFG_ACTIVE_CHANNELS, CFG_DATA_BITS'(act));
                if ($urandom_range(0, 3) != 0)
                    write_reg(CFG_RATE_RATIO, pick_ratio());
            end
            if ($urandom_range(0, 5) == 0) begin
                spare = CFG_IDX_BITS'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_TOP));
                write_reg(spare, CFG_DATA_BITS'($urandom()));
            end
            phase_len = (active_q == 0) ? $urandom_range(3, 8) : $urandom_range(20, 50);
            tx_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len; k++) begin
                if (active_q != 0 && $urandom_range(0, 99) < 85)
                    ch = CHAN_BITS'($urandom_range(0, (active_q > CHAN_COUNT ?
                                                        CHAN_COUNT : active_q) - 1));
                else
                    ch = CHAN_BITS'($urandom());
                s = pick_sample();
                live++;
                if ($urandom_range(0, 39) == 0)
                    drain_outputs();
                hold_sender(tx_steady ? 0 : gap_len());
                send_sample(ch, s, ROW_PRED);
            end
        end

        smp_bus.valid <= 1'b0;
        while (awaited.size() > 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/chr_pkg.sv
sv/chr_smp_if.sv
sv/chr_res_if.sv
sv/chr_cfg_if.sv
sv/chr_ctrl.sv
sv/chr_datapath.sv
sv/cubic_hermite_resampler_core.sv
sv/chr_checker.sv
verif/tb_cubic_hermite_resampler_core.sv
